FILE: rtl/pidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Widths, register indexes and reset values of the dual-form PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // Sample and fixed-point format
    localparam int SAMPLE_W   = 16;             // feedback / setpoint width
    localparam int FRAC_W     = 8;              // gain fraction bits
    localparam int GAIN_W     = 16;             // signed Q8.8 gains
    localparam int ERR_W      = SAMPLE_W + 1;   // setpoint - feedback never overflows
    localparam int SUM_W      = 32;             // integral sum and its limits
    localparam int DRIVE_W    = 32;
    localparam int ACC_W      = DRIVE_W + FRAC_W;

    // Working width of the accumulator update: widest product plus headroom
    localparam int CALC_W = ((GAIN_W + SUM_W) > ACC_W) ? (GAIN_W + SUM_W + 2) : (ACC_W + 2);

    localparam logic signed [CALC_W-1:0] ACC_MAX = CALC_W'((65'sd1 <<< (ACC_W - 1)) - 65'sd1);
    localparam logic signed [CALC_W-1:0] ACC_MIN = -ACC_MAX - CALC_W'(1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_FORM_SEL  = 3'd4,
        REG_SUM_UPPER = 3'd5,
        REG_SUM_LOWER = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        FORM_POSITIONAL  = 1'b0,
        FORM_INCREMENTAL = 1'b1
    } pid_form_t;

    localparam logic signed [SUM_W-1:0] SUM_UPPER_RST = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LOWER_RST = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

FILE: rtl/pid_controller_dual_form.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_dual_form
// Discrete PID controller, positional or incremental form, one sample a cycle while m_ready is high.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                   | Dir | Role
//  ---------+-----------------------------------------+-----+--------------------------
//  s_       | s_valid s_ready s_feedback              | in  | feedback sample requests
//  m_       | m_valid m_ready m_drive m_sum_clamped   | out | controller output requests
//           | m_drive_saturated                       |     |
//  cfg_     | cfg_valid cfg_ready cfg_index cfg_data  | in  | register writes
//
//  Flow   : one sample per clock sustained while m_ready stays high; the
//           accepted sample is held in the input register, then the result
//           register loads from the compute pass once it is free or drained.
//           The compute pass is the three gain multipliers plus one add tree
//           and saturation, all combinational between the two registers.
//  Reset  : aresetn low, synchronous. Gains/setpoint clear, sum limits open to
//           the full int32 range, error history and accumulator clear.
//  Stalls : the input register empties whenever the result register is free
//           or drained that cycle, so s_ready follows m_ready combinationally.
//           cfg_ready is always high; writes belong to idle periods.
//
module pid_controller_dual_form (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [pidc_pkg::SAMPLE_W-1:0]   s_feedback,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pidc_pkg::DRIVE_W-1:0]    m_drive,
    output logic                                   m_sum_clamped,
    output logic                                   m_drive_saturated,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import pidc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] setpoint_reg;
    logic signed [GAIN_W-1:0]   gain_p_reg;
    logic signed [GAIN_W-1:0]   gain_i_reg;
    logic signed [GAIN_W-1:0]   gain_d_reg;
    pid_form_t                  form_reg;
    logic signed [SUM_W-1:0]    sum_upper_reg;
    logic signed [SUM_W-1:0]    sum_lower_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg  <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            form_reg      <= FORM_POSITIONAL;
            sum_upper_reg <= SUM_UPPER_RST;
            sum_lower_reg <= SUM_LOWER_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_SETPOINT:  setpoint_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_GAIN_P:    gain_p_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    gain_i_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    gain_d_reg    <= cfg_data[GAIN_W-1:0];
                REG_FORM_SEL:  form_reg      <= pid_form_t'(cfg_data[0]);
                REG_SUM_UPPER: sum_upper_reg <= cfg_data[SUM_W-1:0];
                REG_SUM_LOWER: sum_lower_reg <= cfg_data[SUM_W-1:0];
                default: ;     // unmapped index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] fb_reg;
    logic                       advance;

    // Stage fires when a sample waits and the result register can take it
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            fb_reg <= s_feedback;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [ERR_W-1:0] older_err_reg;
    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // ------------------------------------------------------------------
    // Compute pass
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]          err;
    logic signed [ERR_W:0]            diff1;      // e - prev
    logic signed [ERR_W+1:0]          diff2;      // e - 2*prev + older
    logic signed [SUM_W:0]            sum_raw;
    logic signed [SUM_W-1:0]          sum_next;
    logic                             clamp_next;

    logic signed [ERR_W:0]            op_p;
    logic signed [SUM_W-1:0]          op_i;
    logic signed [ERR_W+1:0]          op_d;
    logic signed [GAIN_W+ERR_W:0]     prod_p;
    logic signed [GAIN_W+SUM_W-1:0]   prod_i;
    logic signed [GAIN_W+ERR_W+1:0]   prod_d;

    logic signed [CALC_W-1:0]         total;
    logic signed [ACC_W-1:0]          acc_next;
    logic                             sat_next;
    logic signed [ACC_W-1:0]          acc_shift;
    logic                             frac_nz;
    logic signed [DRIVE_W-1:0]        drive_next;

    always_comb begin
        err     = ERR_W'(setpoint_reg) - ERR_W'(fb_reg);
        diff1   = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err_reg);
        diff2   = (ERR_W+2)'(err) - ((ERR_W+2)'(prev_err_reg) <<< 1)
                + (ERR_W+2)'(older_err_reg);

        // Integral clamp: the upper limit is tested first and wins
        sum_raw    = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err);
        clamp_next = 1'b1;
        if (sum_raw >= (SUM_W+1)'(sum_upper_reg)) begin
            sum_next = sum_upper_reg;
        end else if (sum_raw <= (SUM_W+1)'(sum_lower_reg)) begin
            sum_next = sum_lower_reg;
        end else begin
            sum_next   = sum_raw[SUM_W-1:0];
            clamp_next = 1'b0;
        end

        // One multiplier per gain; the form picks the operands
        if (form_reg == FORM_INCREMENTAL) begin
            op_p = diff1;
            op_i = SUM_W'(err);
            op_d = diff2;
        end else begin
            op_p = (ERR_W+1)'(err);
            op_i = sum_next;
            op_d = (ERR_W+2)'(diff1);
        end
        prod_p = gain_p_reg * op_p;
        prod_i = gain_i_reg * op_i;
        prod_d = gain_d_reg * op_d;

        total = CALC_W'(prod_p) + CALC_W'(prod_i) + CALC_W'(prod_d);
        if (form_reg == FORM_INCREMENTAL) begin
            total = total + CALC_W'(acc_reg);
        end

        sat_next = 1'b1;
        if (total > ACC_MAX) begin
            acc_next = ACC_MAX[ACC_W-1:0];
        end else if (total < ACC_MIN) begin
            acc_next = ACC_MIN[ACC_W-1:0];
        end else begin
            acc_next = total[ACC_W-1:0];
            sat_next = 1'b0;
        end

        // Drop the fraction, rounding toward zero on negative values
        acc_shift  = acc_next >>> FRAC_W;
        frac_nz    = |(acc_next & ACC_W'((65'd1 << FRAC_W) - 65'd1));
        drive_next = acc_shift[DRIVE_W-1:0]
                   + DRIVE_W'(acc_next[ACC_W-1] && frac_nz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg  <= '0;
            older_err_reg <= '0;
            error_sum_reg <= '0;
            acc_reg       <= '0;
        end else if (advance) begin
            prev_err_reg <= err;
            acc_reg      <= acc_next;
            if (form_reg == FORM_INCREMENTAL) begin
                older_err_reg <= prev_err_reg;
            end else begin
                error_sum_reg <= sum_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                      m_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic                      sum_clamped_reg;
    logic                      drive_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg       <= drive_next;
            sum_clamped_reg <= clamp_next && (form_reg == FORM_POSITIONAL);
            drive_sat_reg   <= sat_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_drive           = drive_reg;
    assign m_sum_clamped     = sum_clamped_reg;
    assign m_drive_saturated = drive_sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("result register empty after a compute pass");

    a_incr_keeps_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (form_reg == FORM_INCREMENTAL) |=> $stable(error_sum_reg))
        else $error("integral sum moved in incremental form");

    a_clamp_to_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (form_reg == FORM_POSITIONAL) && clamp_next
        |=> (error_sum_reg == $past(sum_upper_reg))
            || (error_sum_reg == $past(sum_lower_reg)))
        else $error("clamped sum is not a limit");

    a_sat_drive_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && drive_sat_reg
        |-> (drive_reg == {1'b0, {(DRIVE_W-1){1'b1}}})
            || (drive_reg == {1'b1, {(DRIVE_W-1){1'b0}}}))
        else $error("saturated result not at a rail");

endmodule
